/* sv/sorted_sleep_timer_queue_macros.svh */
// Assertion macros for the sorted sleep timer queue.
`ifndef SORTED_SLEEP_TIMER_QUEUE_MACROS_SVH
`define SORTED_SLEEP_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define SSTQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

/* sv/sst_pkg.sv */
// Shared types and constants of the sorted sleep timer queue.
package sst_pkg;

   localparam int TICK_W     = 63;
   localparam int DL_W       = 64;
   localparam int DUR_W      = 32;
   localparam int ID_FIELD_W = 8;
   localparam int MAX_WAKE   = 16;
   localparam int STAT_OCC_W = 7;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_SLEEP = 1'b1;

   typedef enum logic [1:0] {
      KIND_WOKEN,
      KIND_QUEUED,
      KIND_IMMEDIATE,
      KIND_REJECTED
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ID_FIELD_W-1:0]   woken_id;
      logic [TICK_W-1:0]       now_ticks;
      logic                    last;
   } rsp_item_type;

   typedef struct packed {
      logic                    idle;
      logic [STAT_OCC_W-1:0]   occ;
   } ctrl_status_type;

endpackage

/* sv/sst_if.sv */
// Request and response channel interfaces of the sorted sleep timer queue.
interface sst_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [7:0]         sleeper_id;
   logic signed [31:0] duration;

   modport source (output valid, func, sleeper_id, duration, input ready);
   modport sink (input valid, func, sleeper_id, duration, output ready);
endinterface

interface sst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  woken_id;
   logic [62:0] now_ticks;
   logic        last;

   modport source (output valid, kind, woken_id, now_ticks, last, input ready);
   modport sink (input valid, kind, woken_id, now_ticks, last, output ready);
endinterface

/* sv/sst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/sst_ctrl.sv */
// Queue sequencer: ordered insert, front wake-up and tick counter over the entry RAM.
module sst_ctrl
   import sst_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   sst_req_if.sink                 req,
   output logic                    ram_wr_en,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_wr_addr,
   output logic [DL_W+((ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W)-1:0] ram_wr_data,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] ram_rd_addr,
   input  logic [DL_W+((ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W)-1:0] ram_rd_data,
   input  logic                    out_free,
   output logic                    res_valid,
   output rsp_item_type            res_item,
   output ctrl_status_type         status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
   localparam int CNT_W = $clog2(MAX_WAKE + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_INS,
      ST_PUT,
      ST_EMIT,
      ST_WAKE,
      ST_FLUSH
   } state_type;

   state_type          state_ff, state_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [PTR_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]   wcnt_ff, wcnt_in;
   logic               pend_ff, pend_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic               func_ff, func_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [DUR_W-1:0]   dur_ff, dur_in;
   logic [DL_W-1:0]    dl_ff, dl_in;
   kind_type           kind_ff, kind_in;

   logic [DL_W-1:0]    rd_dl;
   logic [ID_W-1:0]    rd_id;
   logic               due;

   // Physical slot of a logical position in the circular entry table.
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] offs);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_W + 1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign rd_dl = ram_rd_data[DL_W+ID_W-1 -: DL_W];
   assign rd_id = ram_rd_data[ID_W-1:0];
   assign due   = DL_W'(tick_ff) >= rd_dl;

   assign req.ready     = (state_ff == ST_IDLE);
   assign status.idle   = (state_ff == ST_IDLE);
   assign status.occ    = STAT_OCC_W'(occ_ff);

   always_comb begin
      state_in    = state_ff;
      tick_in     = tick_ff;
      head_in     = head_ff;
      occ_in      = occ_ff;
      cur_in      = cur_ff;
      wcnt_in     = wcnt_ff;
      pend_in     = pend_ff;
      pend_id_in  = pend_id_ff;
      func_in     = func_ff;
      id_in       = id_ff;
      dur_in      = dur_ff;
      dl_in       = dl_ff;
      kind_in     = kind_ff;
      ram_rd_addr = head_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = {dl_ff, id_ff};
      res_valid   = 1'b0;
      res_item    = '{kind: KIND_WOKEN, woken_id: ID_FIELD_W'(pend_id_ff),
                      now_ticks: tick_ff, last: 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in = req.func;
               id_in   = req.sleeper_id[ID_W-1:0];
               dur_in  = req.duration;
               if (req.func == FUNC_TICK) begin
                  tick_in = tick_ff + TICK_W'(1);
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (func_ff == FUNC_TICK) begin
               wcnt_in = '0;
               pend_in = 1'b0;
               state_in = (occ_ff == '0) ? ST_IDLE : ST_WAKE;
            end else if (dur_ff == '0 || dur_ff[DUR_W-1]) begin
               kind_in  = KIND_IMMEDIATE;
               state_in = ST_EMIT;
            end else if (occ_ff == OCC_W'(QUEUE_DEPTH)) begin
               kind_in  = KIND_REJECTED;
               state_in = ST_EMIT;
            end else begin
               kind_in = KIND_QUEUED;
               dl_in   = DL_W'(tick_ff) + DL_W'(dur_ff);
               if (occ_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  // Walk from the tail toward the front, shifting later deadlines up.
                  cur_in      = PTR_W'(occ_ff - OCC_W'(1));
                  ram_rd_addr = slot_of(head_ff, cur_in);
                  state_in    = ST_INS;
               end
            end
         end
         ST_INS: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_of(head_ff, cur_ff + PTR_W'(1));
            if (rd_dl > dl_ff) begin
               ram_wr_data = ram_rd_data;
               if (cur_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  cur_in      = cur_ff - PTR_W'(1);
                  ram_rd_addr = slot_of(head_ff, cur_in);
               end
            end else begin
               occ_in   = occ_ff + OCC_W'(1);
               state_in = ST_EMIT;
            end
         end
         ST_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = head_ff;
            occ_in      = occ_ff + OCC_W'(1);
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               res_valid = 1'b1;
               res_item  = '{kind: kind_ff, woken_id: ID_FIELD_W'(id_ff),
                             now_ticks: tick_ff, last: 1'b1};
               state_in  = ST_IDLE;
            end
         end
         ST_WAKE: begin
            if (due) begin
               // Hold the previous sleeper until we know whether it is the last one.
               if (!pend_ff || out_free) begin
                  res_valid   = pend_ff;
                  pend_in     = 1'b1;
                  pend_id_in  = rd_id;
                  head_in     = slot_of(head_ff, PTR_W'(1));
                  occ_in      = occ_ff - OCC_W'(1);
                  wcnt_in     = wcnt_ff + CNT_W'(1);
                  ram_rd_addr = head_in;
                  if (occ_ff == OCC_W'(1) || wcnt_ff == CNT_W'(MAX_WAKE - 1)) begin
                     state_in = ST_FLUSH;
                  end
               end
            end else begin
               state_in = pend_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               res_valid     = 1'b1;
               res_item.last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tick_ff  <= '0;
         head_ff  <= '0;
         occ_ff   <= '0;
         wcnt_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         wcnt_ff  <= wcnt_in;
         pend_ff  <= pend_in;
      end
      cur_ff     <= cur_in;
      pend_id_ff <= pend_id_in;
      func_ff    <= func_in;
      id_ff      <= id_in;
      dur_ff     <= dur_in;
      dl_ff      <= dl_in;
      kind_ff    <= kind_in;
   end

endmodule

/* sv/sst_out_reg.sv */
// Output register that holds one response transaction while the receiver stalls.
module sst_out_reg
   import sst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_item_type  item,
   output logic          free,
   sst_rsp_if.source     rsp
);

   logic          valid_ff, valid_in;
   rsp_item_type  item_ff;

   assign free     = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.kind      = item_ff.kind;
   assign rsp.woken_id  = item_ff.woken_id;
   assign rsp.now_ticks = item_ff.now_ticks;
   assign rsp.last      = item_ff.last;

endmodule

/* sv/sorted_sleep_timer_queue.sv */
// Sleep timer queue: tick counter plus a deadline-ordered table of sleepers.
//
// req_chan carries one transaction per timer tick (func 0) or sleep request
// (func 1); it is taken only while the sequencer is idle. rsp_chan returns the
// results: a sleep request gives exactly one (queued, immediate or rejected),
// a tick gives one woken result per expired sleeper from the front of the
// table, up to 16, with last set on the final one, or none when nothing is due.
// Sleepers live in a circular table in one RAM with a registered read; the
// sequencer takes one RAM entry per cycle unless held by the output register.
// Sequence: an immediate or rejected reply passes the start and emit states;
// an ordered insert passes start, insert steps that shift later-deadline
// entries up, put when the new entry goes to the front, then emit; a tick
// passes start, one wake step per woken sleeper, a flush of the final result,
// and one more wake step to find the next sleeper not yet due when the table
// is neither emptied nor at 16 wakes. A new transaction is taken in idle.
// Reset clears the tick counter and empties the table; no sweep is needed.
// A stalled receiver holds the response register, and a wake sequence pauses
// on it until the register frees up.
`include "sorted_sleep_timer_queue_macros.svh"

module sorted_sleep_timer_queue
   import sst_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic       clock,
   input  logic       reset,
   sst_req_if.sink    req_chan,
   sst_rsp_if.source  rsp_chan
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int ID_W  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
   localparam int ENT_W = DL_W + ID_W;

   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [ENT_W-1:0]  ram_rd_data;
   logic              out_free;
   logic              res_valid;
   rsp_item_type      res_item;
   ctrl_status_type   stat;

   sst_ram #(
      .WIDTH (ENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sst_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res_item    (res_item),
      .status      (stat)
   );

   sst_out_reg u_out (
      .clock (clock),
      .reset (reset),
      .load  (res_valid),
      .item  (res_item),
      .free  (out_free),
      .rsp   (rsp_chan)
   );

   `SSTQ_ASSERT_ALWAYS(a_occ_bound, clock, reset,
      stat.occ <= STAT_OCC_W'(QUEUE_DEPTH), "occupancy above queue depth")
   `SSTQ_ASSERT_NOW(a_load_free, clock, reset, res_valid, out_free,
      "result loaded into a stalled output register")
   `SSTQ_ASSERT_NOW(a_occ_step, clock, reset, !$past(reset),
      (stat.occ == $past(stat.occ)) || (stat.occ == $past(stat.occ) + 7'd1) ||
      (stat.occ + 7'd1 == $past(stat.occ)), "occupancy moved by more than one entry")
   `SSTQ_ASSERT_NOW(a_busy_no_accept, clock, reset, !stat.idle, !req_chan.ready,
      "request taken while the sequencer is busy")

endmodule

/* tb/sv/sorted_sleep_timer_queue_test.sv */
// Self-checking testbench of the sorted sleep timer queue: directed table, then random traffic.
module sorted_sleep_timer_queue_test;
   import sst_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 72;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic        func;
      logic [7:0]  id;
      logic [31:0] dur;
      int          reps;
      bit          typed;
      kind_type    t_kind;
      logic [62:0] t_now;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sst_req_if req_bus ();
   sst_rsp_if rsp_bus ();

   sorted_sleep_timer_queue #(
      .QUEUE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (8)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #1 clock = ~clock;

   // Predicted timer state
   logic [62:0] tick_now;
   logic [63:0] table_deadline [TABLE_DEPTH];
   logic [7:0]  table_id [TABLE_DEPTH];
   int          table_fill;

   rsp_item_type sleeper_replies[$];
   int  fail_count = 0;
   bit  no_idle = 1'b0;
   bit  stall_request = 1'b0;
   int  stall_left = 0;

   task automatic apply_timer_op(logic func, logic [7:0] id, logic [31:0] dur);
      rsp_item_type r;
      rsp_item_type held;
      bit have_held;
      int pos;
      int woken;
      logic [63:0] dl;
      have_held = 1'b0;
      woken = 0;
      if (func == FUNC_TICK) begin
         tick_now = tick_now + 63'd1;
         while (table_fill > 0 && woken < MAX_WAKE &&
                {1'b0, tick_now} >= table_deadline[0]) begin
            r.kind = KIND_WOKEN;
            r.woken_id = table_id[0];
            r.now_ticks = tick_now;
            r.last = 1'b0;
            if (have_held) sleeper_replies.push_back(held);
            held = r;
            have_held = 1'b1;
            woken++;
            for (int i = 1; i < table_fill; i++) begin
               table_deadline[i-1] = table_deadline[i];
               table_id[i-1] = table_id[i];
            end
            table_fill--;
         end
         // mark the final wake of this tick
         if (have_held) begin
            held.last = 1'b1;
            sleeper_replies.push_back(held);
         end
      end else begin
         r.woken_id = id;
         r.now_ticks = tick_now;
         r.last = 1'b1;
         if (dur == 32'd0 || dur[31]) begin
            r.kind = KIND_IMMEDIATE;
         end else if (table_fill >= TABLE_DEPTH) begin
            r.kind = KIND_REJECTED;
         end else begin
            dl = {1'b0, tick_now} + {32'd0, dur};
            pos = 0;
            // insert behind every entry with an equal or earlier deadline
            while (pos < table_fill && table_deadline[pos] <= dl) pos++;
            for (int i = table_fill; i > pos; i--) begin
               table_deadline[i] = table_deadline[i-1];
               table_id[i] = table_id[i-1];
            end
            table_deadline[pos] = dl;
            table_id[pos] = id;
            table_fill++;
            r.kind = KIND_QUEUED;
         end
         sleeper_replies.push_back(r);
      end
   endtask

   task automatic offer_transaction(logic f, logic [7:0] id, logic [31:0] dur, bit typed,
                                    rsp_item_type fixed);
      while (!no_idle && $urandom_range(0, 99) < 16) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= f;
      req_bus.sleeper_id <= id;
      req_bus.duration <= dur;
      do @(posedge clock); while (!req_bus.ready);
      // typed rows are immediate or rejected replies and leave the state alone
      if (typed) sleeper_replies.push_back(fixed);
      else apply_timer_op(f, id, dur);
      @(negedge clock);
   endtask

   // Stimulus
   initial begin
      stim_row_type directed_rows [17];
      rsp_item_type fixed;
      logic f;
      logic [7:0] id;
      logic [31:0] dur;
      int pick;

      req_bus.valid = 1'b0;
      req_bus.func = FUNC_TICK;
      req_bus.sleeper_id = 8'd0;
      req_bus.duration = 32'd0;
      tick_now = 63'd0;
      table_fill = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         table_deadline[i] = 64'd0;
         table_id[i] = 8'd0;
      end

      directed_rows = '{
         '{FUNC_SLEEP, 8'h00, 32'h0000_0000, 1, 1'b1, KIND_IMMEDIATE, 63'd0},
         '{FUNC_SLEEP, 8'hFF, 32'h8000_0000, 1, 1'b1, KIND_IMMEDIATE, 63'd0},
         '{FUNC_SLEEP, 8'hA5, 32'hFFFF_FFFF, 1, 1'b1, KIND_IMMEDIATE, 63'd0},
         '{FUNC_TICK,  8'hFF, 32'hFFFF_FFFF, 1, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_SLEEP, 8'h01, 32'h0000_0001, 1, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_SLEEP, 8'h02, 32'h0000_0001, 1, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_SLEEP, 8'h03, 32'h0000_0003, 1, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_SLEEP, 8'h04, 32'h0000_0002, 1, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_TICK,  8'h00, 32'h0000_0000, 3, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_SLEEP, 8'h10, 32'h0000_0004, 16, 1'b0, KIND_WOKEN,    63'd0},
         '{FUNC_SLEEP, 8'hEE, 32'h0000_0005, 1, 1'b1, KIND_REJECTED,  63'd4},
         '{FUNC_SLEEP, 8'hEF, 32'h8000_0001, 1, 1'b1, KIND_IMMEDIATE, 63'd4},
         '{FUNC_TICK,  8'h00, 32'h7FFF_FFFF, 4, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_SLEEP, 8'hFF, 32'h0000_0002, 1, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_TICK,  8'h00, 32'h0000_0000, 2, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_SLEEP, 8'h55, 32'h7FFF_FFFF, 1, 1'b0, KIND_WOKEN,     63'd0},
         '{FUNC_TICK,  8'h00, 32'h0000_0000, 1, 1'b0, KIND_WOKEN,     63'd0}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            id = directed_rows[r].id + 8'(k);
            fixed.kind = directed_rows[r].t_kind;
            fixed.woken_id = id;
            fixed.now_ticks = directed_rows[r].t_now;
            fixed.last = 1'b1;
            offer_transaction(directed_rows[r].func, id, directed_rows[r].dur,
                              directed_rows[r].typed, fixed);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 40 && n < 65);
         if (n == 20) stall_request = 1'b1;
         id = 8'($urandom_range(0, 255));
         dur = $urandom;
         if ($urandom_range(0, 99) < 45) begin
            f = FUNC_TICK;
         end else begin
            f = FUNC_SLEEP;
            pick = $urandom_range(0, 99);
            if (pick < 78) dur = $urandom_range(1, 24);
            else if (pick < 88) dur = dur | 32'h8000_0000;
            else if (pick < 93) dur = 32'd0;
            else dur = $urandom_range(1, 3);
         end
         offer_transaction(f, id, dur, 1'b0, fixed);
      end
      no_idle = 1'b0;
      req_bus.valid <= 1'b0;

      while (sleeper_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver backpressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_left = HOLD_CYCLES;
            stall_request = 1'b0;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // Compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (sleeper_replies.size() == 0) begin
            $error("unexpected result: kind %0d id %0d now %0d", rsp_bus.kind,
                   rsp_bus.woken_id, rsp_bus.now_ticks);
            fail_count++;
         end else begin
            want = sleeper_replies.pop_front();
            if (rsp_bus.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_bus.kind);
               fail_count++;
            end
            if (rsp_bus.woken_id !== want.woken_id) begin
               $error("woken_id: expected %0d, actual %0d", want.woken_id, rsp_bus.woken_id);
               fail_count++;
            end
            if (rsp_bus.now_ticks !== want.now_ticks) begin
               $error("now_ticks: expected %0d, actual %0d", want.now_ticks, rsp_bus.now_ticks);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/sst_pkg.sv
sv/sst_if.sv
sv/sst_ram.sv
sv/sst_ctrl.sv
sv/sst_out_reg.sv
sv/sorted_sleep_timer_queue.sv
tb/sv/sorted_sleep_timer_queue_test.sv
